// ----- hw/rtl/lbp_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package lbp_pkg;

    // default line buffer and frame limits
    localparam int DEF_MAX_WIDTH  = 1024;
    localparam int DEF_MAX_HEIGHT = 1024;

    // field widths
    localparam int CFG_W     = 11;
    localparam int CFG_IDX_W = 2;
    localparam int PIX_W     = 8;
    localparam int BIN_W     = 8;
    localparam int BINS      = 256;
    localparam int COUNT_W   = 21;
    localparam int PCT_W     = 23;

    localparam logic [COUNT_W-1:0] COUNT_MAX   = 21'h1FFFFF;
    localparam logic [PCT_W-1:0]   PERCENT_MAX = 23'd6553600;
    // 100 percent in 16-bit fixed point
    localparam logic [PCT_W-1:0]   PCT_SCALE   = 23'd6553600;

    // opcodes
    localparam logic OPC_PUSH = 1'b0;
    localparam logic OPC_READ = 1'b1;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;

    // one decoded item between front and back
    typedef struct packed {
        logic             is_read;
        logic [PIX_W-1:0] pixel;
        logic [BIN_W-1:0] bin;
    } lbp_item_t;

    // pack the compare bits of existing neighbors into successive low bits
    function automatic logic [7:0] pack_code(input logic [7:0] ge, input logic [7:0] ex);
        logic [7:0] code;
        logic [3:0] k;
        code = '0;
        k = '0;
        for (int i = 0; i < 8; i++) begin
            if (ex[i]) begin
                if (ge[i]) code[k[2:0]] = 1'b1;
                k = k + 4'd1;
            end
        end
        return code;
    endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/lbp_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none

module lbp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             aclk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // one write port, registered read port
    always_ff @(posedge aclk) begin
        if (we) mem[waddr] <= wdata;
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ----- hw/rtl/lbp_div.sv -----
`timescale 1ns / 1ps
`default_nettype none

module lbp_div #(
    parameter int QW = 23,
    parameter int DW = 22
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          start,
    input  wire logic [DW-1:0] hi,
    input  wire logic [QW-1:0] lo,
    input  wire logic [DW-1:0] divisor,
    output logic               done,
    output logic      [QW-1:0] quot
);

    localparam int CNTW = $clog2(QW + 1);

    logic [DW-1:0]   rem_reg;
    logic [QW-1:0]   lo_reg;
    logic [DW-1:0]   d_reg;
    logic [CNTW-1:0] cnt_reg;
    logic            busy_reg;
    logic            done_reg;
    logic [DW:0]     trial;
    logic [DW:0]     diff;
    logic            ge;

    // one restoring step per cycle
    assign trial = {rem_reg, lo_reg[QW-1]};
    assign ge    = trial >= {1'b0, d_reg};
    assign diff  = trial - {1'b0, d_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                rem_reg  <= hi;
                lo_reg   <= lo;
                d_reg    <= divisor;
                cnt_reg  <= '0;
                busy_reg <= 1'b1;
            end else if (busy_reg) begin
                rem_reg <= ge ? diff[DW-1:0] : trial[DW-1:0];
                lo_reg  <= {lo_reg[QW-2:0], ge};
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNTW'(QW - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done = done_reg;
    assign quot = lo_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/lbp_front.sv -----
`timescale 1ns / 1ps
`default_nettype none

module lbp_front (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      s_valid,
    output logic                           s_ready,
    input  wire logic                      s_opcode,
    input  wire logic [lbp_pkg::PIX_W-1:0] s_pixel_value,
    input  wire logic [lbp_pkg::BIN_W-1:0] s_bin_index,
    output lbp_pkg::lbp_item_t             head,
    output logic                           head_valid,
    input  wire logic                      head_pop
);

    import lbp_pkg::*;

    lbp_item_t  q_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] fill_reg;
    logic       push;
    lbp_item_t  decoded;

    // classify the incoming item
    assign decoded.is_read = (s_opcode == OPC_READ);
    assign decoded.pixel   = s_pixel_value;
    assign decoded.bin     = s_bin_index;

    assign s_ready    = (fill_reg != 2'd2);
    assign push       = s_valid && s_ready;
    assign head       = q_reg[rd_ptr_reg];
    assign head_valid = (fill_reg != 2'd0);

    // two-entry queue toward the back end
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end else begin
            if (push) begin
                q_reg[wr_ptr_reg] <= decoded;
                wr_ptr_reg        <= ~wr_ptr_reg;
            end
            if (head_pop) rd_ptr_reg <= ~rd_ptr_reg;
            case ({push, head_pop})
                2'b10:   fill_reg <= fill_reg + 2'd1;
                2'b01:   fill_reg <= fill_reg - 2'd1;
                default: fill_reg <= fill_reg;
            endcase
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/lbp_back.sv -----
`timescale 1ns / 1ps
`default_nettype none

module lbp_back #(
    parameter int MAX_WIDTH  = lbp_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = lbp_pkg::DEF_MAX_HEIGHT
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire lbp_pkg::lbp_item_t          head,
    input  wire logic                        head_valid,
    output logic                             head_pop,
    input  wire logic [lbp_pkg::CFG_W-1:0]   cfg_width,
    input  wire logic [lbp_pkg::CFG_W-1:0]   cfg_height,
    output logic                             out_valid,
    input  wire logic                        out_ready,
    output logic      [lbp_pkg::COUNT_W-1:0] out_count,
    output logic      [lbp_pkg::PCT_W-1:0]   out_percent,
    output logic                             out_hready
);

    import lbp_pkg::*;

    localparam int AW     = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int CW     = $clog2(MAX_WIDTH + 1);
    localparam int RW     = $clog2(MAX_HEIGHT + 1);
    localparam int TW     = CW + RW;
    localparam int PROD_W = COUNT_W + PCT_W;
    localparam int CMPW   = (TW > COUNT_W) ? TW : COUNT_W;

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_P0   = 4'd1;
    localparam logic [3:0] ST_P1   = 4'd2;
    localparam logic [3:0] ST_RD   = 4'd3;
    localparam logic [3:0] ST_WIN  = 4'd4;
    localparam logic [3:0] ST_CODE = 4'd5;
    localparam logic [3:0] ST_UPD  = 4'd6;
    localparam logic [3:0] ST_RDQ  = 4'd7;
    localparam logic [3:0] ST_MUL  = 4'd8;
    localparam logic [3:0] ST_CHK  = 4'd9;
    localparam logic [3:0] ST_DIV  = 4'd10;

    logic [3:0]         state_reg;
    logic [CW-1:0]      col_reg;
    logic [RW-1:0]      row_reg;
    logic [CW-1:0]      pc_reg;
    logic               fc_reg;
    logic [BINS-1:0]    valid_reg;
    logic [1:0]         abv_sel_reg;
    logic [1:0]         cur_sel_reg;
    logic [1:0]         inc_sel_reg;
    logic               pass_second_reg;
    logic               has_up_reg;
    logic               has_dn_reg;
    logic               last_row_reg;
    logic [PIX_W-1:0]   wl_reg [3];
    logic [PIX_W-1:0]   wc_reg [3];
    logic [PIX_W-1:0]   wr_reg [3];
    logic [BIN_W-1:0]   code_reg;
    logic [BIN_W-1:0]   bin_reg;
    logic [COUNT_W-1:0] cnt_reg;
    logic [TW-1:0]      total_reg;
    logic [PROD_W-1:0]  prod_reg;
    logic               out_valid_reg;
    logic [COUNT_W-1:0] out_count_reg;
    logic [PCT_W-1:0]   out_pct_reg;
    logic               out_hready_reg;

    logic [CW-1:0]      w_eff;
    logic [RW-1:0]      h_eff;
    logic [PIX_W-1:0]   lb_q [3];
    logic [PIX_W-1:0]   role_q [3];
    logic [AW-1:0]      lb_raddr;
    logic               lb_write;
    logic [COUNT_W-1:0] hist_q;
    logic [COUNT_W-1:0] hist_old;
    logic [COUNT_W-1:0] hist_wdata;
    logic [BIN_W-1:0]   hist_raddr;
    logic               l_ok;
    logic               r_ok;
    logic [7:0]         ge;
    logic [7:0]         ex;
    logic [BIN_W-1:0]   code_comb;
    logic               col_more;
    logic               row_last;
    logic               div_start;
    logic               div_done;
    logic [PCT_W-1:0]   div_quot;

    // frame size in use: zero counts as one, larger sizes clamp to the buffer limits
    assign w_eff = (cfg_width == '0) ? CW'(1) :
                   (32'(cfg_width) > MAX_WIDTH) ? CW'(MAX_WIDTH) : CW'(cfg_width);
    assign h_eff = (cfg_height == '0) ? RW'(1) :
                   (32'(cfg_height) > MAX_HEIGHT) ? RW'(MAX_HEIGHT) : RW'(cfg_height);

    assign col_more = CW'(col_reg + 1'b1) < w_eff;
    assign row_last = RW'(row_reg + 1'b1) >= h_eff;

    // three row buffers whose roles rotate at each row end
    assign lb_write = (state_reg == ST_IDLE) && head_valid && !head.is_read;
    assign lb_raddr = (state_reg == ST_P0) ? '0 : AW'(pc_reg + 1'b1);

    for (genvar gi = 0; gi < 3; gi++) begin : g_line
        lbp_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_line (
            .aclk  (aclk),
            .we    (lb_write && (inc_sel_reg == 2'(gi))),
            .waddr (col_reg[AW-1:0]),
            .wdata (head.pixel),
            .raddr (lb_raddr),
            .rdata (lb_q[gi])
        );
    end

    assign role_q[0] = lb_q[abv_sel_reg];
    assign role_q[1] = lb_q[cur_sel_reg];
    assign role_q[2] = lb_q[inc_sel_reg];

    // pattern code of the window column
    assign l_ok = (pc_reg != '0);
    assign r_ok = CW'(pc_reg + 1'b1) < w_eff;
    assign ge = {wr_reg[2] >= wc_reg[1], wc_reg[2] >= wc_reg[1], wl_reg[2] >= wc_reg[1],
                 wr_reg[1] >= wc_reg[1], wl_reg[1] >= wc_reg[1],
                 wr_reg[0] >= wc_reg[1], wc_reg[0] >= wc_reg[1], wl_reg[0] >= wc_reg[1]};
    assign ex = {has_dn_reg & r_ok, has_dn_reg, has_dn_reg & l_ok,
                 r_ok, l_ok,
                 has_up_reg & r_ok, has_up_reg, has_up_reg & l_ok};
    assign code_comb = pack_code(ge, ex);

    // histogram bins, cleared through valid bits
    assign hist_raddr = (state_reg == ST_CODE) ? code_comb : head.bin;
    assign hist_old   = valid_reg[code_reg] ? hist_q : '0;
    assign hist_wdata = (hist_old == COUNT_MAX) ? hist_old : hist_old + 1'b1;

    lbp_ram #(.WIDTH(COUNT_W), .DEPTH(BINS)) u_hist (
        .aclk  (aclk),
        .we    (state_reg == ST_UPD),
        .waddr (code_reg),
        .wdata (hist_wdata),
        .raddr (hist_raddr),
        .rdata (hist_q)
    );

    // percent divider
    assign div_start = (state_reg == ST_CHK) && !(CMPW'(cnt_reg) > CMPW'(total_reg));

    lbp_div #(.QW(PCT_W), .DW(TW)) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .hi      (TW'(prod_reg >> PCT_W)),
        .lo      (prod_reg[PCT_W-1:0]),
        .divisor (total_reg),
        .done    (div_done),
        .quot    (div_quot)
    );

    assign head_pop = (state_reg == ST_IDLE) && head_valid &&
                      (!head.is_read || !out_valid_reg);

    // sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            col_reg         <= '0;
            row_reg         <= '0;
            pc_reg          <= '0;
            fc_reg          <= 1'b0;
            valid_reg       <= '0;
            abv_sel_reg     <= 2'd0;
            cur_sel_reg     <= 2'd1;
            inc_sel_reg     <= 2'd2;
            pass_second_reg <= 1'b0;
            has_up_reg      <= 1'b0;
            has_dn_reg      <= 1'b0;
            last_row_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
        end else begin
            if (out_valid_reg && out_ready) out_valid_reg <= 1'b0;
            case (state_reg)
                ST_IDLE: begin
                    if (head_pop && head.is_read) begin
                        bin_reg   <= head.bin;
                        state_reg <= ST_RDQ;
                    end else if (head_pop) begin
                        if (col_reg == '0 && row_reg == '0) begin
                            valid_reg <= '0;
                            fc_reg    <= 1'b0;
                        end
                        if (col_more) begin
                            col_reg <= col_reg + 1'b1;
                        end else begin
                            col_reg      <= '0;
                            last_row_reg <= row_last;
                            pc_reg       <= '0;
                            if (row_reg != '0) begin
                                has_up_reg      <= (32'(row_reg) >= 2);
                                has_dn_reg      <= 1'b1;
                                pass_second_reg <= 1'b0;
                                state_reg       <= ST_P0;
                            end else begin
                                cur_sel_reg <= inc_sel_reg;
                                inc_sel_reg <= cur_sel_reg;
                                if (row_last) begin
                                    has_up_reg      <= 1'b0;
                                    has_dn_reg      <= 1'b0;
                                    pass_second_reg <= 1'b1;
                                    state_reg       <= ST_P0;
                                end else begin
                                    row_reg <= row_reg + 1'b1;
                                end
                            end
                        end
                    end
                end
                ST_P0: begin
                    state_reg <= ST_P1;
                end
                ST_P1: begin
                    for (int r = 0; r < 3; r++) wc_reg[r] <= role_q[r];
                    state_reg <= ST_RD;
                end
                ST_RD: begin
                    state_reg <= ST_WIN;
                end
                ST_WIN: begin
                    for (int r = 0; r < 3; r++) wr_reg[r] <= role_q[r];
                    state_reg <= ST_CODE;
                end
                ST_CODE: begin
                    code_reg  <= code_comb;
                    state_reg <= ST_UPD;
                end
                ST_UPD: begin
                    valid_reg[code_reg] <= 1'b1;
                    for (int r = 0; r < 3; r++) begin
                        wl_reg[r] <= wc_reg[r];
                        wc_reg[r] <= wr_reg[r];
                    end
                    if (r_ok) begin
                        pc_reg    <= pc_reg + 1'b1;
                        state_reg <= ST_RD;
                    end else if (!pass_second_reg) begin
                        abv_sel_reg <= cur_sel_reg;
                        cur_sel_reg <= inc_sel_reg;
                        inc_sel_reg <= abv_sel_reg;
                        if (last_row_reg) begin
                            has_up_reg      <= 1'b1;
                            has_dn_reg      <= 1'b0;
                            pass_second_reg <= 1'b1;
                            pc_reg          <= '0;
                            state_reg       <= ST_P0;
                        end else begin
                            row_reg   <= row_reg + 1'b1;
                            state_reg <= ST_IDLE;
                        end
                    end else begin
                        row_reg   <= '0;
                        fc_reg    <= 1'b1;
                        state_reg <= ST_IDLE;
                    end
                end
                ST_RDQ: begin
                    cnt_reg   <= valid_reg[bin_reg] ? hist_q : '0;
                    total_reg <= TW'(w_eff) * TW'(h_eff);
                    state_reg <= ST_MUL;
                end
                ST_MUL: begin
                    prod_reg  <= PROD_W'(cnt_reg) * PROD_W'(PCT_SCALE);
                    state_reg <= ST_CHK;
                end
                ST_CHK: begin
                    if (CMPW'(cnt_reg) > CMPW'(total_reg)) begin
                        out_valid_reg  <= 1'b1;
                        out_count_reg  <= cnt_reg;
                        out_pct_reg    <= PERCENT_MAX;
                        out_hready_reg <= fc_reg;
                        state_reg      <= ST_IDLE;
                    end else begin
                        state_reg <= ST_DIV;
                    end
                end
                ST_DIV: begin
                    if (div_done) begin
                        out_valid_reg  <= 1'b1;
                        out_count_reg  <= cnt_reg;
                        out_pct_reg    <= div_quot;
                        out_hready_reg <= fc_reg;
                        state_reg      <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign out_valid   = out_valid_reg;
    assign out_count   = out_count_reg;
    assign out_percent = out_pct_reg;
    assign out_hready  = out_hready_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/lbp_3x3_histogram.sv -----
// 3x3 local binary pattern histogram of a grey frame.
// Input channel (s_valid/s_ready): opcode 0 pushes one raster pixel, opcode 1
// reads one histogram bin. Only reads produce an item on the result channel
// (m_valid/m_ready): bin count, percent of the frame (16 fraction bits) and
// a flag that the whole frame has been counted.
// Config channel (cfg_valid/cfg_ready, always ready): index 0 frame width,
// index 1 frame height; write only while the block is idle.
// The last pixel of each row from the second row on starts a pass over the row
// buffers; per column the pass reads the buffers, shifts the window, forms the
// code and does a histogram read-modify-write. The last row of a frame adds a
// second pass. A read goes through the bin read, a multiply and a range check,
// then the one-bit-per-cycle percent divider unless the count exceeds the frame.
// A two-entry queue keeps accepting items while the back end works.
// The histogram is cleared at once by valid bits on the first pixel of a
// frame. Reset returns the block to the start of a frame with 64x64 size.
// When the receiver stalls, the result is held and further pixels still
// flow; the next read waits until the held result is taken.
`timescale 1ns / 1ps
`default_nettype none

module lbp_3x3_histogram #(
    parameter int MAX_WIDTH  = lbp_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = lbp_pkg::DEF_MAX_HEIGHT
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic                          s_opcode,
    input  wire logic [lbp_pkg::PIX_W-1:0]     s_pixel_value,
    input  wire logic [lbp_pkg::BIN_W-1:0]     s_bin_index,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic      [lbp_pkg::COUNT_W-1:0]   m_bin_count,
    output logic      [lbp_pkg::PCT_W-1:0]     m_bin_percent,
    output logic                               m_histogram_ready,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [lbp_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [lbp_pkg::CFG_W-1:0]     cfg_data
);

    import lbp_pkg::*;

    logic [CFG_W-1:0] width_reg;
    logic [CFG_W-1:0] height_reg;
    lbp_item_t        head;
    logic             head_valid;
    logic             head_pop;

    // configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= CFG_W'(64);
            height_reg <= CFG_W'(64);
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                REG_FRAME_WIDTH:  width_reg  <= cfg_data;
                REG_FRAME_HEIGHT: height_reg <= cfg_data;
                default:          ;
            endcase
        end
    end

    // front end: accept and classify items
    lbp_front u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_opcode      (s_opcode),
        .s_pixel_value (s_pixel_value),
        .s_bin_index   (s_bin_index),
        .head          (head),
        .head_valid    (head_valid),
        .head_pop      (head_pop)
    );

    // back end: row passes, histogram and reads
    lbp_back #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .head        (head),
        .head_valid  (head_valid),
        .head_pop    (head_pop),
        .cfg_width   (width_reg),
        .cfg_height  (height_reg),
        .out_valid   (m_valid),
        .out_ready   (m_ready),
        .out_count   (m_bin_count),
        .out_percent (m_bin_percent),
        .out_hready  (m_histogram_ready)
    );

    // percent never exceeds the full-frame value
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_bin_percent <= PERCENT_MAX))
        else $error("percent above full scale");

    // a full queue always presents an item to the back end
    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> head_valid)
        else $error("queue full without a head item");

    // an item is only taken from the queue when one is there
    assert property (@(posedge aclk) disable iff (!aresetn)
        head_pop |-> head_valid)
        else $error("pop from empty queue");

endmodule

`default_nettype wire

// ----- verif/lbp_hist_checker.sv -----
`timescale 1ns / 1ps

module lbp_hist_checker (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    input  logic                            s_ready,
    input  logic                            s_opcode,
    input  logic [lbp_pkg::PIX_W-1:0]       s_pixel_value,
    input  logic [lbp_pkg::BIN_W-1:0]       s_bin_index,
    input  logic                            m_valid,
    input  logic                            m_ready,
    input  logic [lbp_pkg::COUNT_W-1:0]     m_bin_count,
    input  logic [lbp_pkg::PCT_W-1:0]       m_bin_percent,
    input  logic                            m_histogram_ready,
    input  logic                            cfg_valid,
    input  logic                            cfg_ready,
    input  logic [lbp_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [lbp_pkg::CFG_W-1:0]       cfg_data,
    output int                              pending,
    output int                              mismatches
);
    import lbp_pkg::*;

    localparam int LINE_MAX = DEF_MAX_WIDTH;
    localparam int ROWS_MAX = DEF_MAX_HEIGHT;

    typedef struct {
        logic [COUNT_W-1:0] count;
        logic [PCT_W-1:0]   percent;
        logic               ready;
    } bin_result_t;

    // predicted block state
    logic [CFG_W-1:0]   width_reg;
    logic [CFG_W-1:0]   height_reg;
    logic [PIX_W-1:0]   rows [3][LINE_MAX];   // 0 above, 1 current, 2 incoming
    logic [COUNT_W-1:0] hist [BINS];
    int                 col_pos;
    int                 row_pos;
    logic               frame_done;
    bin_result_t        bin_results_q[$];

    function automatic int clamp_dim(input logic [CFG_W-1:0] v, input int hi);
        if (v == 0) return 1;
        if (v > hi) return hi;
        return int'(v);
    endfunction

    // codes of the current row, with the row above and below where present
    function automatic void tally_row(input bit has_up, input bit has_dn, input int w);
        logic [7:0] code;
        int         nb;
        int         col;
        logic [7:0] centre;
        for (int c = 0; c < w; c++) begin
            code = '0;
            nb = 0;
            centre = rows[1][c];
            for (int dr = 0; dr < 3; dr++) begin
                if ((dr == 0 && !has_up) || (dr == 2 && !has_dn)) continue;
                for (int dc = -1; dc <= 1; dc++) begin
                    col = c + dc;
                    if (dr == 1 && dc == 0) continue;
                    if (col < 0 || col >= w) continue;
                    if (rows[dr][col] >= centre) code[nb] = 1'b1;
                    nb++;
                end
            end
            if (hist[code] != COUNT_MAX) hist[code]++;
        end
    endfunction

    function automatic void push_pixel(input logic [PIX_W-1:0] px);
        int w;
        int h;
        bit last_row;
        w = clamp_dim(width_reg, LINE_MAX);
        h = clamp_dim(height_reg, ROWS_MAX);
        if (col_pos == 0 && row_pos == 0) begin
            foreach (hist[i]) hist[i] = '0;
            frame_done = 1'b0;
        end
        rows[2][col_pos] = px;
        if (col_pos + 1 < w) begin
            col_pos++;
            return;
        end
        col_pos = 0;
        last_row = (row_pos + 1 >= h);
        if (row_pos >= 1) begin
            tally_row(row_pos >= 2, 1'b1, w);
            rows[0] = rows[1];
        end
        rows[1] = rows[2];
        if (last_row) begin
            tally_row(row_pos >= 1, 1'b0, w);
            row_pos = 0;
            frame_done = 1'b1;
        end else begin
            row_pos++;
        end
    endfunction

    function automatic bin_result_t read_bin(input logic [BIN_W-1:0] b);
        bin_result_t r;
        longint unsigned total;
        longint unsigned pct;
        total = longint'(clamp_dim(width_reg, LINE_MAX)) * clamp_dim(height_reg, ROWS_MAX);
        pct = (longint'(hist[b]) * 100 * 65536) / total;
        if (pct > PERCENT_MAX) pct = PERCENT_MAX;
        r.count = hist[b];
        r.percent = pct[PCT_W-1:0];
        r.ready = frame_done;
        return r;
    endfunction

    assign pending = bin_results_q.size();

    always @(posedge aclk) begin
        bin_result_t want;
        if (!aresetn) begin
            width_reg <= 11'd64;
            height_reg <= 11'd64;
            foreach (hist[i]) hist[i] = '0;
            col_pos = 0;
            row_pos = 0;
            frame_done = 1'b0;
            mismatches = 0;
        end else begin
            // compare an outgoing result with the oldest prediction
            if (m_valid && m_ready) begin
                if (bin_results_q.size() == 0) begin
                    $error("result item with nothing expected");
                    mismatches++;
                end else begin
                    want = bin_results_q.pop_front();
                    if (m_bin_count !== want.count) begin
                        $error("bin_count: expected %0d, got %0d", want.count, m_bin_count);
                        mismatches++;
                    end
                    if (m_bin_percent !== want.percent) begin
                        $error("bin_percent: expected %0d, got %0d", want.percent,
                               m_bin_percent);
                        mismatches++;
                    end
                    if (m_histogram_ready !== want.ready) begin
                        $error("histogram_ready: expected %0d, got %0d", want.ready,
                               m_histogram_ready);
                        mismatches++;
                    end
                end
            end
            // predict from an incoming item
            if (s_valid && s_ready) begin
                if (s_opcode == OPC_READ) bin_results_q.push_back(read_bin(s_bin_index));
                else push_pixel(s_pixel_value);
            end
            // register writes
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == REG_FRAME_WIDTH) width_reg <= cfg_data;
                else if (cfg_index == REG_FRAME_HEIGHT) height_reg <= cfg_data;
            end
        end
    end

endmodule

// ----- verif/tb_lbp_3x3_histogram.sv -----
`timescale 1ns / 1ps

module tb_lbp_3x3_histogram;
    import lbp_pkg::*;

    localparam int STALL_LIMIT = 30000;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_valid = 1'b0;
    logic                 s_ready;
    logic                 s_opcode = OPC_PUSH;
    logic [PIX_W-1:0]     s_pixel_value = '0;
    logic [BIN_W-1:0]     s_bin_index = '0;
    logic                 m_valid;
    logic                 m_ready = 1'b0;
    logic [COUNT_W-1:0]   m_bin_count;
    logic [PCT_W-1:0]     m_bin_percent;
    logic                 m_histogram_ready;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = REG_FRAME_WIDTH;
    logic [CFG_W-1:0]     cfg_data = '0;
    int                   pending;
    int                   mismatches;

    int tx_gap_max = 0;
    int rx_stall_max = 0;
    int rx_stall = 0;
    int idle_cycles = 0;
    int width_now = 64;
    int pixels_sent = 0;
    int reads_sent = 0;
    int frames_sent = 0;
    int settings_used = 0;

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    lbp_3x3_histogram u_top (.*);

    lbp_hist_checker u_chk (.*);

    // receiver: random stall after every taken result
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (m_valid && m_ready) begin
            rx_stall = $urandom_range(0, rx_stall_max);
            m_ready <= (rx_stall == 0);
        end else if (rx_stall > 0) begin
            rx_stall--;
            m_ready <= (rx_stall == 0);
        end else begin
            m_ready <= 1'b1;
        end
    end

    // watchdog on cycles with no traffic
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("lbp_3x3_histogram: mismatch");
            $finish;
        end
    end

    task automatic send_item(input logic op, input logic [PIX_W-1:0] px,
                             input logic [BIN_W-1:0] bin);
        int gap;
        gap = $urandom_range(0, tx_gap_max);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_opcode <= op;
        s_pixel_value <= px;
        s_bin_index <= bin;
        do @(posedge aclk); while (!(s_valid && s_ready));
        if (op == OPC_READ) reads_sent++;
        else pixels_sent++;
    endtask

    task automatic read_random_bin();
        logic [BIN_W-1:0] b;
        case ($urandom_range(0, 3))
            0, 1: b = BIN_W'($urandom_range(0, 15));
            2: b = BIN_W'($urandom_range(0, 255));
            default: b = 8'hff - BIN_W'($urandom_range(0, 15));
        endcase
        send_item(OPC_READ, '0, b);
    endtask

    // wait out results and any row pass still running
    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (2 * (4 * width_now + 2) + 60) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge aclk); while (!(cfg_valid && cfg_ready));
        cfg_valid <= 1'b0;
    endtask

    task automatic set_size(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h);
        drain();
        write_reg(REG_FRAME_WIDTH, w);
        write_reg(REG_FRAME_HEIGHT, h);
        width_now = (w == 0) ? 1 : (w > 1024) ? 1024 : int'(w);
        settings_used++;
    endtask

    // one frame of pixels with reads mixed in, then a few reads of the result
    task automatic run_frame(input int npix, input int read_pct);
        int               mode;
        logic [PIX_W-1:0] base;
        mode = $urandom_range(0, 2);
        base = PIX_W'($urandom_range(0, 253));
        tx_gap_max = ($urandom_range(0, 2) == 0) ? 0 : 11;
        for (int i = 0; i < npix; i++) begin
            case (mode)
                0: send_item(OPC_PUSH, PIX_W'($urandom_range(0, 255)), '0);
                1: send_item(OPC_PUSH, PIX_W'(base + $urandom_range(0, 2)), '0);
                default: send_item(OPC_PUSH, base, '0);
            endcase
            if ($urandom_range(0, 99) < read_pct) read_random_bin();
        end
        frames_sent++;
        repeat ($urandom_range(1, 4)) read_random_bin();
    endtask

    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reads of the empty histogram straight after reset
        send_item(OPC_READ, '0, 8'h00);
        send_item(OPC_READ, '0, 8'hff);

        // zero size acts as one pixel; extreme pixel values
        set_size(11'd0, 11'd0);
        send_item(OPC_PUSH, 8'h00, '0);
        send_item(OPC_READ, '0, 8'h00);
        send_item(OPC_PUSH, 8'hff, '0);
        send_item(OPC_READ, '0, 8'h00);
        send_item(OPC_READ, '0, 8'h01);

        // 3x3 frame: ties, extremes, partial-frame reads
        set_size(11'd3, 11'd3);
        send_item(OPC_PUSH, 8'h00, '0);
        send_item(OPC_PUSH, 8'hff, '0);
        send_item(OPC_PUSH, 8'h80, '0);
        send_item(OPC_PUSH, 8'h80, '0);
        send_item(OPC_READ, '0, 8'h07);
        send_item(OPC_PUSH, 8'h80, '0);
        send_item(OPC_PUSH, 8'h7f, '0);
        send_item(OPC_PUSH, 8'hff, '0);
        send_item(OPC_PUSH, 8'h00, '0);
        send_item(OPC_READ, '0, 8'h00);
        send_item(OPC_PUSH, 8'h80, '0);
        send_item(OPC_READ, '0, 8'hff);
        send_item(OPC_READ, '0, 8'h1f);

        // random small sizes, one to three frames each
        while (pixels_sent + reads_sent < 820) begin
            int w;
            int h;
            w = $urandom_range(1, 9);
            h = $urandom_range(1, 9);
            rx_stall_max = ($urandom_range(0, 2) == 0) ? 0 : 11;
            set_size(CFG_W'(w), CFG_W'(h));
            repeat ($urandom_range(1, 3)) run_frame(w * h, 15);
        end

        // oversized registers clamp to the maximum, start of a large frame
        rx_stall_max = 11;
        set_size(11'd2047, 11'd2047);
        run_frame(120, 15);

        drain();
        $display("covered %0d pixels and %0d bin reads over %0d frames in %0d sizes",
                 pixels_sent, reads_sent, frames_sent, settings_used);
        $display("full frames up to 9x9 plus the start of a clamped 1024x1024 frame, with gaps");
        if (mismatches == 0)
            $display("lbp_3x3_histogram: match");
        else
            $display("lbp_3x3_histogram: mismatch");
        $finish;
    end

endmodule

// ----- filelist.f -----
hw/rtl/lbp_pkg.sv
hw/rtl/lbp_ram.sv
hw/rtl/lbp_div.sv
hw/rtl/lbp_front.sv
hw/rtl/lbp_back.sv
hw/rtl/lbp_3x3_histogram.sv
verif/lbp_hist_checker.sv
verif/tb_lbp_3x3_histogram.sv
